// ===== hdl/postfix_stack_evaluator_defines.svh =====
// Assertion macros for the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pse_pkg.sv =====
// Shared types and constants of the postfix stack evaluator.
package pse_pkg;

  localparam int unsigned Q_W             = 32;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned DIVD_W          = Q_W + FRAC_W;
  localparam int unsigned RES_W           = DIVD_W + 1;
  localparam int unsigned STACK_DEPTH_DEF = 128;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_APPLY  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    cmd_e                  cmd;
    op_e                   operator_code;
    logic signed [Q_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] answer;
    logic                  underflow_seen;
    logic                  overflow_seen;
    logic                  divide_by_zero_seen;
    logic                  saturated_seen;
    logic                  leftover_seen;
  } out_t;

  typedef struct packed {
    logic under;
    logic over;
    logic div0;
    logic sat;
    logic left;
  } err_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator: operand stack memory and sequencer.
//
//   channel   direction  handshake                 beat
//   in        input      in_valid_i / in_ready_o   one token: cmd, operator, operand
//   out       output     out_valid_o / out_ready_i answer and five sticky flags
//
// Token path: a push or an unused command ends in ST_IDLE, a finish passes ST_FIN,
// an operator pops via ST_RD_B and ST_RD_A to ST_EXEC, then add or subtract goes
// to ST_CLIP, multiply via ST_MUL, divide via ST_DIV until the one-bit-per-cycle
// divider is done, and divide by zero back to ST_IDLE. The registered stack memory
// read port sets the pop states of every operator. Reset empties the stack at once
// through the fill count; the memory itself is never cleared. A finish waits in
// ST_FIN while an earlier result is still held in the output register.
`include "postfix_stack_evaluator_defines.svh"

module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_RD_A,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_CLIP,
    ST_FIN
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        cnt_q;
  err_t                    err_q;
  op_e                     op_q;
  logic                    na_q, nb_q, top_ok_q;
  logic signed [Q_W-1:0]   a_q, b_q;
  logic signed [63:0]      prod_q;
  logic signed [RES_W-1:0] res_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic [Q_W-1:0]          stack_mem [STACK_DEPTH];
  logic [Q_W-1:0]          rdata_q;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic [Q_W-1:0]          mem_wdata;

  logic                    accept;
  logic [CNT_W-1:0]        cnt_dec;
  logic                    sat_hi, sat_lo;
  logic [Q_W-1:0]          clip_val, div0_val;
  logic                    div_start;
  div_stat_t               div_stat;
  logic signed [RES_W-1:0] div_quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_dec    = cnt_q - 1'b1;

  // Saturate the wide result to Q16.16
  always_comb begin
    sat_hi   = !res_q[RES_W-1] && (|res_q[RES_W-2:Q_W-1]);
    sat_lo   = res_q[RES_W-1] && !(&res_q[RES_W-2:Q_W-1]);
    clip_val = sat_hi ? {1'b0, {(Q_W-1){1'b1}}} :
               sat_lo ? {1'b1, {(Q_W-1){1'b0}}} : res_q[Q_W-1:0];
    div0_val = {a_q[Q_W-1], {(Q_W-1){~a_q[Q_W-1]}}};
  end

  // Drive the stack memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cnt_q[IDX_W-1:0];
    mem_raddr = cnt_dec[IDX_W-1:0];
    mem_wdata = clip_val;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_data_i.cmd == CMD_PUSH && cnt_q < DEPTH_CNT) begin
          mem_we    = 1'b1;
          mem_wdata = in_data_i.operand_value;
        end
        if (accept && (in_data_i.cmd == CMD_APPLY || in_data_i.cmd == CMD_FINISH)) begin
          mem_re = 1'b1;
        end
      end
      ST_RD_B: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_q[IDX_W-1:0];
      end
      ST_EXEC: begin
        if (op_q == OP_DIV && b_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = div0_val;
        end
      end
      ST_CLIP: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Write the stack entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read the stack entry into the rdata_q register
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= stack_mem[mem_raddr];
    end
  end

  assign div_start = (state_q == ST_EXEC) && (op_q == OP_DIV) && (b_q != '0);

  pse_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (a_q),
    .den_i   (b_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Sequence tokens, hold flags and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      err_q       <= '0;
      op_q        <= OP_ADD;
      na_q        <= 1'b0;
      nb_q        <= 1'b0;
      top_ok_q    <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      prod_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the beat once taken; a finish reloads it itself
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_data_i.cmd)
              CMD_PUSH: begin
                if (cnt_q < DEPTH_CNT) begin
                  cnt_q <= cnt_q + 1'b1;
                end else begin
                  err_q.over <= 1'b1;
                end
              end
              CMD_APPLY: begin
                op_q  <= in_data_i.operator_code;
                nb_q  <= (cnt_q != '0);
                na_q  <= (cnt_q >= TWO_CNT);
                cnt_q <= (cnt_q >= TWO_CNT) ? (cnt_q - TWO_CNT) : '0;
                if (cnt_q < TWO_CNT) begin
                  err_q.under <= 1'b1;
                end
                state_q <= ST_RD_B;
              end
              CMD_FINISH: begin
                top_ok_q <= (cnt_q != '0);
                if (cnt_q == '0) begin
                  err_q.under <= 1'b1;
                end
                if (cnt_q > CNT_W'(1)) begin
                  err_q.left <= 1'b1;
                end
                cnt_q   <= '0;
                state_q <= ST_FIN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD_B: begin
          b_q     <= nb_q ? rdata_q : '0;
          state_q <= ST_RD_A;
        end
        ST_RD_A: begin
          a_q     <= na_q ? rdata_q : '0;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          case (op_q)
            OP_ADD: begin
              res_q   <= RES_W'(a_q) + RES_W'(b_q);
              state_q <= ST_CLIP;
            end
            OP_SUB: begin
              res_q   <= RES_W'(a_q) - RES_W'(b_q);
              state_q <= ST_CLIP;
            end
            OP_MUL: begin
              prod_q  <= 64'(a_q) * 64'(b_q);
              state_q <= ST_MUL;
            end
            default: begin
              if (b_q == '0) begin
                err_q.div0 <= 1'b1;
                cnt_q      <= cnt_q + 1'b1;
                state_q    <= ST_IDLE;
              end else begin
                state_q <= ST_DIV;
              end
            end
          endcase
        end
        ST_MUL: begin
          // arithmetic shift rounds toward minus infinity
          res_q   <= RES_W'(prod_q >>> FRAC_W);
          state_q <= ST_CLIP;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            res_q   <= div_quot;
            state_q <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          if (sat_hi || sat_lo) begin
            err_q.sat <= 1'b1;
          end
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_IDLE;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.answer              <= top_ok_q ? rdata_q : '0;
            out_q.underflow_seen      <= err_q.under;
            out_q.overflow_seen       <= err_q.over;
            out_q.divide_by_zero_seen <= err_q.div0;
            out_q.saturated_seen      <= err_q.sat;
            out_q.leftover_seen       <= err_q.left;
            out_valid_q               <= 1'b1;
            err_q                     <= '0;
            state_q                   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Check fill count, divider interlock and the finish clear
  `PSE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= DEPTH_CNT, "stack count beyond depth")
  `PSE_ASSERT_IMP(a_div_lock, div_stat.busy, !in_ready_o, "token taken while dividing")
  `PSE_ASSERT_IMP(a_div_done, div_stat.done, state_q == ST_DIV, "divider done out of step")
  `PSE_ASSERT_NXT(a_fin_clear, accept && in_data_i.cmd == CMD_FINISH, cnt_q == '0,
                  "stack not emptied at finish")

endmodule

// ===== hdl/pse_divider.sv =====
// Iterative signed Q16.16 divider, one quotient bit per cycle.
module pse_divider
  import pse_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Q_W-1:0]   num_i,
  input  logic signed [Q_W-1:0]   den_i,
  output div_stat_t               stat_o,
  output logic signed [RES_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(DIVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

  logic              busy_q, done_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [Q_W-1:0]    rem_q, dvs_q;
  logic [DIVD_W-1:0] quo_q;

  logic [Q_W:0]      num_ext, den_ext, num_mag, den_mag;
  logic [Q_W:0]      shifted, diff;
  logic              fits;
  logic [RES_W-1:0]  quo_ext;

  // Take magnitudes of both operands
  always_comb begin
    num_ext = {num_i[Q_W-1], num_i};
    den_ext = {den_i[Q_W-1], den_i};
    num_mag = num_i[Q_W-1] ? (~num_ext + 1'b1) : num_ext;
    den_mag = den_i[Q_W-1] ? (~den_ext + 1'b1) : den_ext;
  end

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    shifted = {rem_q, quo_q[DIVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
  end

  // Step the restoring division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= num_i[Q_W-1] ^ den_i[Q_W-1];
        step_q <= '0;
        rem_q  <= '0;
        dvs_q  <= den_mag[Q_W-1:0];
        quo_q  <= {num_mag[Q_W-1:0], {FRAC_W{1'b0}}};
      end else if (busy_q) begin
        rem_q  <= fits ? diff[Q_W-1:0] : shifted[Q_W-1:0];
        quo_q  <= {quo_q[DIVD_W-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Apply the sign, truncating toward zero
  assign quo_ext = {1'b0, quo_q};
  assign quot_o  = neg_q ? $signed(-quo_ext) : $signed(quo_ext);

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
